// ===== src/lightmap_atlas_block_allocator_macros.svh =====
// Assertion macros shared by the atlas allocator modules.
`ifndef LIGHTMAP_ATLAS_BLOCK_ALLOCATOR_MACROS_SVH
`define LIGHTMAP_ATLAS_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define LAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/lab_pkg.sv =====
// Types and constants shared by the atlas block allocator.
`timescale 1ns / 1ps
package lab_pkg;

    localparam int LAB_ATLAS_WIDTH  = 1024;
    localparam int LAB_ATLAS_HEIGHT = 1024;

    typedef struct packed {
        logic [10:0] block_width;
        logic [10:0] block_height;
    } t_req;

    typedef struct packed {
        logic        alloc_ok;
        logic [9:0]  x_pos;
        logic [10:0] y_pos;
    } t_res;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWD,
        ST_BWD,
        ST_CHK,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic fwd;
        logic bwd;
        logic chk;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic w_skip;
        logic pass_end;
        logic upd_need;
        logic upd_last;
    } t_sts;

endpackage

// ===== src/lab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lab_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lab_ctrl.sv =====
// Controller state machine that sequences the clear, scan and update passes.
`timescale 1ns / 1ps
`include "lightmap_atlas_block_allocator_macros.svh"
module lab_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lab_pkg::t_sts i_sts,
    output lab_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    lab_pkg::t_state r_state;
    lab_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lab_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lab_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = lab_pkg::ST_IDLE;
            end
            lab_pkg::ST_IDLE: begin
                if (i_start) n_state = i_sts.w_skip ? lab_pkg::ST_CHK : lab_pkg::ST_FWD;
            end
            lab_pkg::ST_FWD: begin
                if (i_sts.pass_end) n_state = lab_pkg::ST_BWD;
            end
            lab_pkg::ST_BWD: begin
                if (i_sts.pass_end) n_state = lab_pkg::ST_CHK;
            end
            lab_pkg::ST_CHK: begin
                n_state = i_sts.upd_need ? lab_pkg::ST_UPD : lab_pkg::ST_DONE;
            end
            lab_pkg::ST_UPD: begin
                if (i_sts.upd_last) n_state = lab_pkg::ST_DONE;
            end
            lab_pkg::ST_DONE: begin
                n_state = lab_pkg::ST_IDLE;
            end
            default: begin
                n_state = lab_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_busy     = 1'b1;
        o_done     = 1'b0;
        case (r_state)
            lab_pkg::ST_CLEAR: o_cmd.clr = 1'b1;
            lab_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            lab_pkg::ST_FWD:  o_cmd.fwd = 1'b1;
            lab_pkg::ST_BWD:  o_cmd.bwd = 1'b1;
            lab_pkg::ST_CHK:  o_cmd.chk = 1'b1;
            lab_pkg::ST_UPD:  o_cmd.upd = 1'b1;
            lab_pkg::ST_DONE: o_done = 1'b1;
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    `LAB_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "Accepted beat did not raise busy.")
    `LAB_ASSERT_NXT(a_bwd_to_chk, i_clk, i_rst_n, r_state == lab_pkg::ST_BWD && i_sts.pass_end, r_state == lab_pkg::ST_CHK, "Backward scan end did not reach the check.")
    `LAB_ASSERT_NXT(a_chk_done, i_clk, i_rst_n, r_state == lab_pkg::ST_CHK && !i_sts.upd_need, o_done, "Result without update was not strobed.")

endmodule

// ===== src/lab_dp.sv =====
// Datapath with the column height memory, block max scan and column update.
`timescale 1ns / 1ps
`include "lightmap_atlas_block_allocator_macros.svh"
module lab_dp #(
    parameter int ATLAS_WIDTH  = lab_pkg::LAB_ATLAS_WIDTH,
    parameter int ATLAS_HEIGHT = lab_pkg::LAB_ATLAS_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lab_pkg::t_req i_req,
    input  lab_pkg::t_cmd i_cmd,
    output lab_pkg::t_sts o_sts,
    output lab_pkg::t_res o_res
);

    localparam int AAW = $clog2(ATLAS_WIDTH);
    localparam int HW  = $clog2(ATLAS_HEIGHT + 1);
    localparam int CW  = (($clog2(ATLAS_WIDTH + 1) > 11) ? $clog2(ATLAS_WIDTH + 1) : 11) + 1;
    localparam int SW  = ((HW > 11) ? HW : 11) + 1;

    logic [10:0]    r_w;
    logic [10:0]    r_h;
    logic [AAW-1:0] r_ptr;
    logic           r_iss_done;
    logic           r_dv;
    logic [AAW-1:0] r_dp;
    logic [10:0]    r_cnt;
    logic [HW-1:0]  r_run;
    logic [HW-1:0]  r_best;
    logic [AAW-1:0] r_bx;
    logic           r_found;
    logic [AAW-1:0] r_uend;

    logic           w_zero;
    logic           w_big;
    logic [HW-1:0]  col_q;
    logic [HW-1:0]  pre_q;
    logic [10:0]    w_last;
    logic [HW-1:0]  pre_val;
    logic [HW-1:0]  suf_max;
    logic [HW-1:0]  suf_val;
    logic [HW-1:0]  wmax;
    logic           w_cand;
    logic           w_take;
    logic           w_iss;
    logic           w_end;
    logic [SW-1:0]  w_sum;
    logic           w_ok;
    logic           col_we;
    logic [HW-1:0]  col_wdata;
    logic [AAW-1:0] pre_raddr;
    logic [31:0]    bx_ext;
    logic [31:0]    best_ext;

    assign w_zero    = (i_req.block_width == 11'd0);
    assign w_big     = (CW'(i_req.block_width) >= CW'(ATLAS_WIDTH));
    assign w_last    = r_w - 11'd1;
    assign pre_val   = (r_cnt == 11'd0) ? col_q : ((col_q > r_run) ? col_q : r_run);
    assign suf_max   = (col_q > r_run) ? col_q : r_run;
    assign suf_val   = (r_cnt == w_last) ? col_q : suf_max;
    assign wmax      = (suf_val > pre_q) ? suf_val : pre_q;
    assign w_cand    = ((CW'(r_dp) + CW'(r_w)) < CW'(ATLAS_WIDTH));
    assign w_take    = i_cmd.bwd && r_dv && w_cand && (wmax < HW'(ATLAS_HEIGHT))
                       && (wmax <= r_best);
    assign w_iss     = (i_cmd.fwd || i_cmd.bwd) && !r_iss_done;
    assign w_end     = r_dv && ((i_cmd.fwd && (r_dp == AAW'(ATLAS_WIDTH - 1)))
                       || (i_cmd.bwd && (r_dp == '0)));
    assign w_sum     = SW'(r_best) + SW'(r_h);
    assign w_ok      = r_found && (w_sum <= SW'(ATLAS_HEIGHT));
    assign col_we    = i_cmd.clr || i_cmd.upd;
    assign col_wdata = i_cmd.clr ? '0 : w_sum[HW-1:0];
    assign pre_raddr = AAW'(CW'(r_ptr) + CW'(r_w) - CW'(1));

    lab_ram #(
        .WIDTH (HW),
        .DEPTH (ATLAS_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_ptr),
        .i_wdata (col_wdata),
        .i_raddr (r_ptr),
        .o_rdata (col_q)
    );

    lab_ram #(
        .WIDTH (HW),
        .DEPTH (ATLAS_WIDTH)
    ) u_pre_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fwd && r_dv),
        .i_waddr (r_dp),
        .i_wdata (pre_val),
        .i_raddr (pre_raddr),
        .o_rdata (pre_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_iss_done <= 1'b0;
            r_dv       <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_dv <= w_iss;
            if (col_we) begin
                r_ptr <= r_ptr + AAW'(1);
            end else if (i_cmd.load) begin
                r_ptr      <= '0;
                r_iss_done <= 1'b0;
                r_found    <= w_zero;
            end else if (i_cmd.chk) begin
                r_ptr <= r_bx;
            end else if (w_iss) begin
                if (i_cmd.fwd) begin
                    if (r_ptr == AAW'(ATLAS_WIDTH - 1)) begin
                        r_iss_done <= 1'b1;
                    end else begin
                        r_ptr <= r_ptr + AAW'(1);
                    end
                end else begin
                    if (r_ptr == '0) begin
                        r_iss_done <= 1'b1;
                    end else begin
                        r_ptr <= r_ptr - AAW'(1);
                    end
                end
            end else if (i_cmd.fwd && w_end) begin
                r_ptr      <= AAW'(ATLAS_WIDTH - 1);
                r_iss_done <= 1'b0;
            end
            if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dp <= r_ptr;
        if (i_cmd.load) begin
            r_w    <= i_req.block_width;
            r_h    <= i_req.block_height;
            r_cnt  <= '0;
            r_run  <= '0;
            r_bx   <= w_zero ? AAW'(ATLAS_WIDTH - 1) : '0;
            r_best <= w_zero ? '0 : HW'(ATLAS_HEIGHT);
        end
        if (i_cmd.fwd && r_dv) begin
            if (w_end) begin
                r_run <= '0;
            end else begin
                r_run <= pre_val;
                r_cnt <= (r_cnt == w_last) ? 11'd0 : r_cnt + 11'd1;
            end
        end
        if (i_cmd.bwd && r_dv) begin
            r_run <= suf_val;
            r_cnt <= (r_cnt == 11'd0) ? w_last : r_cnt - 11'd1;
        end
        if (w_take) begin
            r_best <= wmax;
            r_bx   <= r_dp;
        end
        if (i_cmd.chk) begin
            r_uend <= AAW'(CW'(r_bx) + CW'(r_w) - CW'(1));
        end
    end

    assign o_sts.clr_last = (r_ptr == AAW'(ATLAS_WIDTH - 1));
    assign o_sts.w_skip   = w_zero || w_big;
    assign o_sts.pass_end = w_end;
    assign o_sts.upd_need = w_ok && (r_w != 11'd0);
    assign o_sts.upd_last = (r_ptr == r_uend);

    assign bx_ext         = 32'(r_bx);
    assign best_ext       = 32'(r_best);
    assign o_res.alloc_ok = w_ok;
    assign o_res.x_pos    = r_found ? bx_ext[9:0] : 10'd0;
    assign o_res.y_pos    = r_found ? best_ext[10:0] : 11'd0;

    `LAB_ASSERT_IMP(a_found_best, i_clk, i_rst_n, r_found, r_best < HW'(ATLAS_HEIGHT), "Found start has a full height.")
    `LAB_ASSERT_IMP(a_upd_window, i_clk, i_rst_n, i_cmd.upd, (r_ptr >= r_bx) && (r_ptr <= r_uend), "Column write outside the chosen window.")
    `LAB_ASSERT_IMP(a_stage_pass, i_clk, i_rst_n, r_dv, i_cmd.fwd || i_cmd.bwd, "Scan stage active outside a scan pass.")

endmodule

// ===== src/lightmap_atlas_block_allocator.sv =====
// Top level of the skyline atlas block allocator.
`timescale 1ns / 1ps
// After reset the block clears its column heights in a pass with busy high. A request is
// taken when start is high and busy is low. A width in range runs a forward and a
// backward scan over the column memory at one column per cycle and then, when the block
// is placed, an update pass over block_width columns. A width of zero or at least
// ATLAS_WIDTH skips both scans. The result beat is shown on o_result for one cycle with
// o_done high and cannot be stalled; busy falls in the following cycle.
module lightmap_atlas_block_allocator #(
    parameter int ATLAS_WIDTH  = lab_pkg::LAB_ATLAS_WIDTH,
    parameter int ATLAS_HEIGHT = lab_pkg::LAB_ATLAS_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  lab_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output lab_pkg::t_res o_result
);

    lab_pkg::t_cmd cmd;
    lab_pkg::t_sts sts;

    lab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    lab_dp #(
        .ATLAS_WIDTH  (ATLAS_WIDTH),
        .ATLAS_HEIGHT (ATLAS_HEIGHT)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_result)
    );

endmodule
